>>> hw/rtl/uitf_pkg.sv
// ----------------------------------------------------------------------------
// uitf_pkg: shared definitions for the unsigned integer text formatter
// Holds the radix and length codes, the job record from the front end to the
// back end, the back end state type and the character and BCD helpers.
// ----------------------------------------------------------------------------
package uitf_pkg;

    localparam int VALUE_W       = 64;
    localparam int PREC_W        = 6;
    localparam int MAX_PRECISION = 60;
    localparam int BUFFER_DEPTH  = 64;
    localparam int BUF_AW        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W         = BUF_AW + 1;
    localparam int BCD_DIGITS    = 20;
    localparam int WORK_W        = 4 * BCD_DIGITS;
    localparam int STEP_W        = $clog2(VALUE_W);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Precision saturates at the smaller of the two limits.
    localparam int PREC_LIMIT = (MAX_PRECISION < BUFFER_DEPTH - 2) ?
                                MAX_PRECISION : BUFFER_DEPTH - 2;

    localparam logic [1:0] RADIX_DEC    = 2'd0;
    localparam logic [1:0] RADIX_OCT    = 2'd1;
    localparam logic [1:0] RADIX_HEX_LO = 2'd2;
    localparam logic [1:0] RADIX_HEX_UP = 2'd3;

    // The unused length code keeps all 64 bits, like LEN_64.
    localparam logic [1:0] LEN_32       = 2'd0;
    localparam logic [1:0] LEN_16       = 2'd1;
    localparam logic [1:0] LEN_64       = 2'd2;
    localparam logic [1:0] LEN_RESERVED = 2'd3;

    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_LOWER_X = 8'h78;
    localparam logic [7:0] CHR_UPPER_X = 8'h58;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         radix;
        logic [PREC_W-1:0]  acc;
        logic               is_zero;
        logic               zero_char_en;
        logic               zero_char_space;
        logic               oct_prefix;
        logic               hex_prefix;
    } uitf_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_DIGITS,
        ST_OCT_PFX,
        ST_PAD,
        ST_HEX_X,
        ST_HEX_0,
        ST_EMIT
    } back_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base_chr;
        base_chr = upper ? CHR_UPPER_A : CHR_LOWER_A;
        if (d < 4'd10)
        begin
            digit_char = CHR_ZERO + {4'b0, d};
        end
        else
        begin
            digit_char = base_chr + {4'b0, d} - 8'd10;
        end
    endfunction

    // One step of the shift-and-add-3 binary to BCD conversion.
    function automatic logic [WORK_W-1:0] dabble_step(input logic [WORK_W-1:0] w,
                                                      input logic bit_in);
        logic [WORK_W-1:0] adj;
        adj = w;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (w[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = w[4*i +: 4] + 4'd3;
            end
        end
        dabble_step = {adj[WORK_W-2:0], bit_in};
    endfunction

endpackage

>>> hw/rtl/unsigned_integer_text_formatter_core.sv
// ----------------------------------------------------------------------------
// unsigned_integer_text_formatter_core: printf-style unsigned conversion
// Turns a 64-bit value with format flags into decimal, octal or hex text.
// ----------------------------------------------------------------------------
// Usage: drive the request fields and raise start; the request transfers on
// a rising edge where start is high and busy is low. Up to two requests wait
// in a queue while an earlier one is being converted; busy is high while
// the queue is full.
// Each character appears on character for exactly one cycle with strobe
// high, most significant first, and is_last marks the final character of a
// conversion. A conversion with empty text gives no strobe at all. The
// receiver cannot stall the output; characters of one conversion always
// come on consecutive cycles.
// Steps per request, once the back end picks it up: a load step, the
// binary to BCD shift loop for decimal only, one digit per cycle, the
// octal prefix, one pad character per cycle and a final check, the two
// hex prefix characters, and then one output character per cycle. The
// first character appears in the cycle after the buffer read starts. The
// character buffer is filled completely before it is read back.
// Reset clears the queue and the sequencer; no output is in flight after it.
// ----------------------------------------------------------------------------
module unsigned_integer_text_formatter_core
    import uitf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    input  logic [1:0]         radix_mode,
    input  logic [1:0]         trunc_mode,
    input  logic               precision_given,
    input  logic [PREC_W-1:0]  precision,
    input  logic               width_given,
    input  logic               alt_form,
    output logic               strobe,
    output logic [7:0]         character,
    output logic               is_last
);

    uitf_job_t front_job;
    uitf_job_t q_head;
    logic      q_empty;
    logic      q_full;
    logic      q_pop;
    logic      q_push;

    assign busy   = q_full;
    assign q_push = start && !q_full;

    uitf_front u_front
    (
        .value           (value),
        .radix_mode      (radix_mode),
        .trunc_mode      (trunc_mode),
        .precision_given (precision_given),
        .precision       (precision),
        .width_given     (width_given),
        .alt_form        (alt_form),
        .job             (front_job)
    );

    uitf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    uitf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .strobe    (strobe),
        .character (character),
        .is_last   (is_last)
    );

    // The last-character mark only rides on a character transfer.
    assert property (@(posedge clk) disable iff (!rst_n) is_last |-> strobe)
        else $error("is_last without strobe");

    // Characters of one conversion come without gaps.
    assert property (@(posedge clk) disable iff (!rst_n) (strobe && !is_last) |=> strobe)
        else $error("gap inside a conversion");

    // The strobe is low in the cycle after the last character of a conversion; a new conversion needs setup first.
    assert property (@(posedge clk) disable iff (!rst_n) (strobe && is_last) |=> !strobe)
        else $error("conversion started without setup");

    // The back end only takes a job that is waiting in the queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("job taken from an empty queue");

endmodule

>>> hw/rtl/uitf_front.sv
// ----------------------------------------------------------------------------
// uitf_front: request classifier
// Cuts an octal or hex value to the selected length, saturates the precision
// and works out the zero-value text and the prefix decisions for one request.
// ----------------------------------------------------------------------------
module uitf_front
    import uitf_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    input  logic [1:0]         radix_mode,
    input  logic [1:0]         trunc_mode,
    input  logic               precision_given,
    input  logic [PREC_W-1:0]  precision,
    input  logic               width_given,
    input  logic               alt_form,
    output uitf_job_t          job
);

    logic [VALUE_W-1:0] cut;
    logic [PREC_W-1:0]  acc;
    logic               is_oct;
    logic               is_hex;
    logic               is_zero;
    logic               zero_space;

    always_comb
    begin
        if (radix_mode == RADIX_DEC)
        begin
            cut = value;
        end
        else if (trunc_mode == LEN_32)
        begin
            cut = {32'b0, value[31:0]};
        end
        else if (trunc_mode == LEN_16)
        begin
            cut = {48'b0, value[15:0]};
        end
        else
        begin
            cut = value;
        end
    end

    assign acc     = (precision > PREC_W'(PREC_LIMIT)) ? PREC_W'(PREC_LIMIT) : precision;
    assign is_oct  = (radix_mode == RADIX_OCT);
    assign is_hex  = (radix_mode == RADIX_HEX_LO) || (radix_mode == RADIX_HEX_UP);
    assign is_zero = (cut == '0);

    // An explicit zero precision with a width prints a zero value as a space,
    // except in octal alternate form, which always shows its zero.
    assign zero_space = precision_given && (acc == '0) && width_given && !(is_oct && alt_form);

    always_comb
    begin
        job.value           = cut;
        job.radix           = radix_mode;
        job.acc             = acc;
        job.is_zero         = is_zero;
        job.zero_char_space = zero_space;
        job.zero_char_en    = zero_space || width_given || !precision_given;
        job.oct_prefix      = is_oct && alt_form && !is_zero;
        job.hex_prefix      = is_hex && alt_form && !is_zero;
    end

endmodule

>>> hw/rtl/uitf_queue.sv
// ----------------------------------------------------------------------------
// uitf_queue: job queue
// A short first-in first-out queue that lets the front end take a new
// request while the back end is still producing text.
// ----------------------------------------------------------------------------
module uitf_queue
    import uitf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  uitf_job_t push_job,
    input  logic      pop,
    output uitf_job_t head,
    output logic      empty,
    output logic      full
);

    uitf_job_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/uitf_back.sv
// ----------------------------------------------------------------------------
// uitf_back: text builder and emitter
// Converts one job into characters least significant first in a character
// buffer, then reads the buffer back in reverse, one character per cycle.
// ----------------------------------------------------------------------------
module uitf_back
    import uitf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  uitf_job_t head,
    input  logic      empty,
    output logic      pop,
    output logic      strobe,
    output logic [7:0] character,
    output logic      is_last
);

    back_state_t        state_reg;
    back_state_t        state_next;
    uitf_job_t          job_reg;
    uitf_job_t          job_next;
    logic [WORK_W-1:0]  work_reg;
    logic [WORK_W-1:0]  work_next;
    logic [VALUE_W-1:0] bin_reg;
    logic [VALUE_W-1:0] bin_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [CNT_W-1:0]   wcount_reg;
    logic [CNT_W-1:0]   wcount_next;
    logic [BUF_AW-1:0]  ridx_reg;
    logic [BUF_AW-1:0]  ridx_next;
    logic               strobe_reg;
    logic               last_reg;
    logic [7:0]         rd_data_reg;

    logic [7:0]         buffer_mem [BUFFER_DEPTH];

    logic               wr_req;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic               rd_last;
    logic               upper;
    logic               is_oct;
    logic [WORK_W-1:0]  work_shift;
    logic [3:0]         digit;
    logic [CNT_W-1:0]   cnt_after;

    assign upper      = (job_reg.radix == RADIX_HEX_UP);
    assign is_oct     = (job_reg.radix == RADIX_OCT);
    assign work_shift = is_oct ? (work_reg >> 3) : (work_reg >> 4);
    assign digit      = is_oct ? {1'b0, work_reg[2:0]} : work_reg[3:0];

    // The buffer never overflows for legal precision, but a write past the
    // end is dropped all the same.
    assign wr_en     = wr_req && (wcount_reg < CNT_W'(BUFFER_DEPTH));
    assign cnt_after = wr_en ? (wcount_reg + CNT_W'(1)) : wcount_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        work_next   = work_reg;
        bin_next    = bin_reg;
        step_next   = step_reg;
        ridx_next   = ridx_reg;
        pop         = 1'b0;
        wr_req      = 1'b0;
        wr_data     = CHR_ZERO;
        rd_en       = 1'b0;
        rd_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    job_next  = head;
                    bin_next  = head.value;
                    step_next = '0;
                    if (head.radix == RADIX_DEC)
                    begin
                        work_next  = '0;
                        state_next = ST_DABBLE;
                    end
                    else
                    begin
                        work_next  = {{(WORK_W - VALUE_W){1'b0}}, head.value};
                        state_next = ST_DIGITS;
                    end
                end
            end
            ST_DABBLE:
            begin
                work_next = dabble_step(work_reg, bin_reg[VALUE_W-1]);
                bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VALUE_W - 1))
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (job_reg.is_zero)
                begin
                    wr_req     = job_reg.zero_char_en;
                    wr_data    = job_reg.zero_char_space ? CHR_SPACE : CHR_ZERO;
                    state_next = ST_OCT_PFX;
                end
                else
                begin
                    wr_req    = 1'b1;
                    wr_data   = digit_char(digit, upper);
                    work_next = work_shift;
                    if (work_shift == '0)
                    begin
                        state_next = ST_OCT_PFX;
                    end
                end
            end
            ST_OCT_PFX:
            begin
                wr_req     = job_reg.oct_prefix;
                state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if (wcount_reg < CNT_W'(job_reg.acc))
                begin
                    wr_req = 1'b1;
                end
                else
                begin
                    state_next = ST_HEX_X;
                end
            end
            ST_HEX_X:
            begin
                wr_req     = job_reg.hex_prefix;
                wr_data    = upper ? CHR_UPPER_X : CHR_LOWER_X;
                state_next = ST_HEX_0;
            end
            ST_HEX_0:
            begin
                wr_req     = job_reg.hex_prefix;
                ridx_next  = cnt_after[BUF_AW-1:0] - BUF_AW'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (wcount_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_last   = (ridx_reg == '0);
                    ridx_next = ridx_reg - BUF_AW'(1);
                    if (ridx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_IDLE)
        begin
            wcount_next = '0;
        end
        else
        begin
            wcount_next = cnt_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wcount_reg <= '0;
            step_reg   <= '0;
            ridx_reg   <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wcount_reg <= wcount_next;
            step_reg   <= step_next;
            ridx_reg   <= ridx_next;
            strobe_reg <= rd_en;
            last_reg   <= rd_last;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        work_reg <= work_next;
        bin_reg  <= bin_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buffer_mem[wcount_reg[BUF_AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= buffer_mem[ridx_reg];
        end
    end

    assign strobe    = strobe_reg;
    assign character = rd_data_reg;
    assign is_last   = last_reg;

endmodule
